// ===== hdl/hcb_pkg.sv =====
// Shared types and fixed field widths for the Huffman code builder.
package hcb_pkg;

    // Fixed widths of the request and result fields
    localparam int IN_WEIGHT_W = 15;
    localparam int INDEX_W     = 4;
    localparam int CODE_W      = 15;
    localparam int LENGTH_W    = 4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_MERGE,
        S_WALK
    } hcb_state_t;

    // Control from the sequencer to the two-minimum unit
    typedef struct packed {
        logic clear;
        logic sample;
    } hcb_scan_ctrl_t;

endpackage

// ===== hdl/hcb_weight_ram.sv =====
// Node weight storage: one write port, one registered read port.
module hcb_weight_ram #(
    parameter int DEPTH  = 31,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 19
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hcb_min2_unit.sv =====
// Shared compare unit: tracks the two smallest weights seen during a scan.
module hcb_min2_unit #(
    parameter int NODE_W = 5,
    parameter int SUM_W  = 19
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcb_pkg::hcb_scan_ctrl_t ctrl,
    input  logic [NODE_W-1:0]      sample_idx,
    input  logic [SUM_W-1:0]       sample_weight,
    output logic [NODE_W-1:0]      min1_idx,
    output logic [NODE_W-1:0]      min2_idx,
    output logic [SUM_W-1:0]       min1_weight,
    output logic [SUM_W-1:0]       min2_weight
);

    logic              have1_reg, have1_next;
    logic              have2_reg, have2_next;
    logic [SUM_W-1:0]  w1_reg, w1_next;
    logic [SUM_W-1:0]  w2_reg, w2_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;

    // Compare the new sample against both minima; strict less keeps the earlier index
    always_comb
    begin
        have1_next = have1_reg;
        have2_next = have2_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        if (ctrl.clear)
        begin
            have1_next = 1'b0;
            have2_next = 1'b0;
        end
        else if (ctrl.sample)
        begin
            if (!have1_reg || (sample_weight < w1_reg))
            begin
                if (have1_reg)
                begin
                    have2_next = 1'b1;
                    w2_next    = w1_reg;
                    b_next     = a_reg;
                end
                have1_next = 1'b1;
                w1_next    = sample_weight;
                a_next     = sample_idx;
            end
            else if (!have2_reg || (sample_weight < w2_reg))
            begin
                have2_next = 1'b1;
                w2_next    = sample_weight;
                b_next     = sample_idx;
            end
        end
    end

    // Hold the found flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end
        else
        begin
            have1_reg <= have1_next;
            have2_reg <= have2_next;
        end
    end

    // Hold the minimum weights and their node numbers
    always_ff @(posedge clk)
    begin
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
    end

    assign min1_idx    = a_reg;
    assign min2_idx    = b_reg;
    assign min1_weight = w1_reg;
    assign min2_weight = w2_reg;

endmodule

// ===== hdl/huffman_code_builder.sv =====
// Top level of the Huffman code builder: sequencer, tree links, code walk, result register.
//
// Usage: leaf weights arrive on the leaf channel (leaf_valid / leaf_stall), one request
// per leaf, in load order. The request with last_leaf set closes the set; leaves past
// MAX_LEAVES are dropped, but a dropped last leaf still starts the build.
// While the tree is built and the codes are emitted, leaf_stall stays high.
// For each internal node k (n <= k < 2n-1) the shared compare unit scans nodes 0..k-1,
// one node per cycle through the weight memory read port, then finishes the compare in
// the drain state and merges in the merge state.
// Codes then leave on the code channel (code_valid / code_stall), one result per leaf
// in load order, last_code on the final one. Each code is built by walking up from its
// leaf to the root; a receiver stall on the result register can hold it back.
// A stalled result holds in the output register; the next leaf's code waits in the walk.
// After the last code is loaded, leaf_stall drops and the next set may be loaded.
// Reset clears the leaf count, the parent flags and the result valid; no clearing pass.
module huffman_code_builder #(
    parameter int MAX_LEAVES  = 16,
    parameter int WEIGHT_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           leaf_valid,
    output logic                           leaf_stall,
    input  logic [hcb_pkg::IN_WEIGHT_W-1:0] leaf_weight,
    input  logic                           last_leaf,
    output logic                           code_valid,
    input  logic                           code_stall,
    output logic [hcb_pkg::INDEX_W-1:0]    leaf_index,
    output logic [hcb_pkg::CODE_W-1:0]     code_bits,
    output logic [hcb_pkg::LENGTH_W-1:0]   code_length,
    output logic                           last_code
);

    localparam int NODE_COUNT = 2 * MAX_LEAVES - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LEAF_W     = $clog2(MAX_LEAVES);
    localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
    localparam int SUM_W      = WEIGHT_BITS + $clog2(MAX_LEAVES);
    localparam int IN_W       = (WEIGHT_BITS < hcb_pkg::IN_WEIGHT_W) ?
                                WEIGHT_BITS : hcb_pkg::IN_WEIGHT_W;
    localparam int LEN_W      = LEAF_W;

    hcb_pkg::hcb_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic [NODE_W-1:0] j_reg, j_next;
    logic              pipe_valid_reg;
    logic [NODE_W-1:0] pipe_idx_reg;
    logic [NODE_COUNT-1:0] hp_reg;
    logic [NODE_W-1:0] c_reg, c_next;
    logic [LEAF_W-1:0] i_reg, i_next;
    logic [hcb_pkg::CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              out_valid_reg, out_valid_next;

    logic [NODE_W-1:0] parent_reg [NODE_COUNT];
    logic [NODE_W-1:0] left_reg [MAX_LEAVES];

    logic              leaf_take;
    logic              has_room;
    logic [CNT_W-1:0]  n_load;
    logic [NODE_W-1:0] last_k;
    logic              merge_en;
    logic              hp_clear;
    logic              load_out;
    logic              out_free;
    logic              walk_up;
    logic              last_i;
    logic [NODE_W-1:0] walk_parent;
    logic [NODE_W-1:0] walk_off;
    logic [NODE_W-1:0] merge_off;
    logic              walk_bit;

    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [SUM_W-1:0]  ram_rdata;

    hcb_pkg::hcb_scan_ctrl_t scan_ctrl;
    logic [NODE_W-1:0] min1_idx, min2_idx;
    logic [SUM_W-1:0]  min1_weight, min2_weight;

    // Node weight memory
    hcb_weight_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (NODE_W),
        .DATA_W (SUM_W)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (j_reg),
        .rdata (ram_rdata)
    );

    // Shared two-minimum compare unit
    hcb_min2_unit #(
        .NODE_W (NODE_W),
        .SUM_W  (SUM_W)
    ) u_min2 (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (scan_ctrl),
        .sample_idx    (pipe_idx_reg),
        .sample_weight (ram_rdata),
        .min1_idx      (min1_idx),
        .min2_idx      (min2_idx),
        .min1_weight   (min1_weight),
        .min2_weight   (min2_weight)
    );

    // Decode handshakes and walk terms
    assign leaf_stall  = (state_reg != hcb_pkg::S_LOAD);
    assign leaf_take   = leaf_valid && (state_reg == hcb_pkg::S_LOAD);
    assign has_room    = (count_reg < CNT_W'(MAX_LEAVES));
    assign n_load      = count_reg + CNT_W'(has_room);
    assign last_k      = NODE_W'(n_reg) + NODE_W'(n_reg) - NODE_W'(2);
    assign out_free    = !out_valid_reg || !code_stall;
    assign walk_parent = parent_reg[c_reg];
    assign walk_off    = walk_parent - NODE_W'(n_reg);
    assign merge_off   = k_reg - NODE_W'(n_reg);
    assign walk_bit    = (left_reg[walk_off[LEAF_W-1:0]] != c_reg);
    assign walk_up     = hp_reg[c_reg];
    assign last_i      = ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg);
    assign code_valid  = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcb_pkg::S_LOAD:
            begin
                if (leaf_take && last_leaf)
                begin
                    if (n_load == CNT_W'(1))
                        state_next = hcb_pkg::S_WALK;
                    else
                        state_next = hcb_pkg::S_SCAN;
                end
            end
            hcb_pkg::S_SCAN:
            begin
                if (j_reg == k_reg - NODE_W'(1))
                    state_next = hcb_pkg::S_DRAIN;
            end
            hcb_pkg::S_DRAIN:
            begin
                state_next = hcb_pkg::S_MERGE;
            end
            hcb_pkg::S_MERGE:
            begin
                if (k_reg == last_k)
                    state_next = hcb_pkg::S_WALK;
                else
                    state_next = hcb_pkg::S_SCAN;
            end
            hcb_pkg::S_WALK:
            begin
                if (!walk_up && out_free && last_i)
                    state_next = hcb_pkg::S_LOAD;
            end
            default:
            begin
                state_next = hcb_pkg::S_LOAD;
            end
        endcase
    end

    // Datapath controls and next values
    always_comb
    begin
        count_next       = count_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        c_next           = c_reg;
        i_next           = i_reg;
        code_next        = code_reg;
        len_next         = len_reg;
        ram_we           = 1'b0;
        ram_waddr        = k_reg;
        ram_wdata        = min1_weight + min2_weight;
        scan_ctrl.clear  = 1'b0;
        // Sample only scanned nodes that are still parentless
        scan_ctrl.sample = pipe_valid_reg && !hp_reg[pipe_idx_reg];
        merge_en         = 1'b0;
        hp_clear         = 1'b0;
        load_out         = 1'b0;
        unique case (state_reg)
            hcb_pkg::S_LOAD:
            begin
                if (leaf_take)
                begin
                    if (has_room)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = NODE_W'(count_reg);
                        ram_wdata  = SUM_W'(leaf_weight[IN_W-1:0]);
                        count_next = n_load;
                    end
                    if (last_leaf)
                    begin
                        n_next          = n_load;
                        k_next          = NODE_W'(n_load);
                        j_next          = '0;
                        c_next          = '0;
                        i_next          = '0;
                        code_next       = '0;
                        len_next        = '0;
                        scan_ctrl.clear = 1'b1;
                    end
                end
            end
            hcb_pkg::S_SCAN:
            begin
                j_next = j_reg + NODE_W'(1);
            end
            hcb_pkg::S_DRAIN:
            begin
                j_next = '0;
            end
            hcb_pkg::S_MERGE:
            begin
                ram_we          = 1'b1;
                merge_en        = 1'b1;
                k_next          = k_reg + NODE_W'(1);
                j_next          = '0;
                scan_ctrl.clear = 1'b1;
            end
            hcb_pkg::S_WALK:
            begin
                if (walk_up)
                begin
                    // Climb one level, adding this edge's bit above those below it
                    code_next = code_reg | (hcb_pkg::CODE_W'(walk_bit) << len_reg);
                    len_next  = len_reg + LEN_W'(1);
                    c_next    = walk_parent;
                end
                else if (out_free)
                begin
                    load_out  = 1'b1;
                    code_next = '0;
                    len_next  = '0;
                    c_next    = NODE_W'(i_reg) + NODE_W'(1);
                    i_next    = i_reg + LEAF_W'(1);
                    if (last_i)
                    begin
                        count_next = '0;
                        hp_clear   = 1'b1;
                    end
                end
            end
            default:
            begin
                j_next = '0;
            end
        endcase
    end

    // Result valid follows loads and drains
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (!code_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcb_pkg::S_LOAD;
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pipe_valid_reg <= (state_reg == hcb_pkg::S_SCAN);
            out_valid_reg  <= out_valid_next;
        end
    end

    // Parent flags: set on merge, drop after the last code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg <= '0;
        end
        else if (hp_clear)
        begin
            hp_reg <= '0;
        end
        else if (merge_en)
        begin
            hp_reg[min1_idx] <= 1'b1;
            hp_reg[min2_idx] <= 1'b1;
        end
    end

    // Tree links written at each merge
    always_ff @(posedge clk)
    begin
        if (merge_en)
        begin
            parent_reg[min1_idx]           <= k_reg;
            parent_reg[min2_idx]           <= k_reg;
            left_reg[merge_off[LEAF_W-1:0]] <= min1_idx;
        end
    end

    // Sequencer counters and walk registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        pipe_idx_reg <= j_reg;
        c_reg        <= c_next;
        i_reg        <= i_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            leaf_index  <= hcb_pkg::INDEX_W'(i_reg);
            code_bits   <= code_reg;
            code_length <= hcb_pkg::LENGTH_W'(len_reg);
            last_code   <= last_i;
        end
    end

endmodule
